FILE: hdl/bbea_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the reciprocal table of the edge-aware 3x3 box blur.
// Used by every module of the block but bbea_ram; depends on nothing else.

package bbea_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    localparam int CH_W        = 8;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_W      = NUM_W + RECIP_W;

    localparam int FIFO_DEPTH  = 16;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

    typedef struct packed {
        pixel_t pix;
        logic   last;
        logic   fend;
    } result_t;

    // Per-item control carried down the pipeline: masks select the window cells
    // that lie inside the frame for the first (a) and second (b) result.
    typedef struct packed {
        logic       wr;
        logic       va;
        logic       vb;
        logic       last_a;
        logic       fend_a;
        logic [2:0] rowm;
        logic [2:0] cola;
        logic [2:0] colb;
    } ctrl_t;

    // ceil(2^18 / (2*count)); exact for numerators up to 2*9*255+9.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd5:    m = 18'd26215;
            4'd6:    m = 18'd21846;
            4'd7:    m = 18'd18725;
            4'd8:    m = 18'd16384;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/bbea_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module bbea_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/bbea_win_sum.sv
`timescale 1ns / 1ps
// Masked per-channel sum and cell count over the 3x3 window.
// Depends on bbea_pkg.

module bbea_win_sum (
    input  bbea_pkg::pixel_t            win [3][3],
    input  logic [2:0]                  colm,
    input  logic [2:0]                  rowm,
    output bbea_pkg::sum_t              sums,
    output logic [bbea_pkg::CNT_W-1:0]  count
);

    always_comb
    begin
        sums  = '0;
        count = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (colm[c] && rowm[r])
                begin
                    sums.red   = sums.red   + bbea_pkg::SUM_W'(win[c][r].red);
                    sums.green = sums.green + bbea_pkg::SUM_W'(win[c][r].green);
                    sums.blue  = sums.blue  + bbea_pkg::SUM_W'(win[c][r].blue);
                    count      = count + bbea_pkg::CNT_W'(1);
                end
            end
        end
    end

endmodule

FILE: hdl/bbea_mean.sv
`timescale 1ns / 1ps
// Rounded mean (2*sum+count)/(2*count) per channel by reciprocal multiplication.
// Depends on bbea_pkg.

module bbea_mean (
    input  bbea_pkg::sum_t             sums,
    input  logic [bbea_pkg::CNT_W-1:0] count,
    output bbea_pkg::pixel_t           mean
);

    logic [bbea_pkg::RECIP_W-1:0] m;
    logic [bbea_pkg::NUM_W-1:0]   num_r, num_g, num_b;
    logic [bbea_pkg::PROD_W-1:0]  prod_r, prod_g, prod_b;

    always_comb
    begin
        m      = bbea_pkg::recip(count);
        num_r  = {sums.red, 1'b0} + bbea_pkg::NUM_W'(count);
        num_g  = {sums.green, 1'b0} + bbea_pkg::NUM_W'(count);
        num_b  = {sums.blue, 1'b0} + bbea_pkg::NUM_W'(count);
        prod_r = bbea_pkg::PROD_W'(num_r) * bbea_pkg::PROD_W'(m);
        prod_g = bbea_pkg::PROD_W'(num_g) * bbea_pkg::PROD_W'(m);
        prod_b = bbea_pkg::PROD_W'(num_b) * bbea_pkg::PROD_W'(m);
        mean.red   = prod_r[bbea_pkg::RECIP_SHIFT +: bbea_pkg::CH_W];
        mean.green = prod_g[bbea_pkg::RECIP_SHIFT +: bbea_pkg::CH_W];
        mean.blue  = prod_b[bbea_pkg::RECIP_SHIFT +: bbea_pkg::CH_W];
    end

endmodule

FILE: hdl/bbea_out_fifo.sv
`timescale 1ns / 1ps
// Result queue that takes up to two results per cycle and hands out one when the reader pops.
// Depends on bbea_pkg.

module bbea_out_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_a,
    input  bbea_pkg::result_t          data_a,
    input  logic                       push_b,
    input  bbea_pkg::result_t          data_b,
    input  logic                       pop,
    output logic                       not_empty,
    output bbea_pkg::result_t          head_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bbea_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    bbea_pkg::result_t first, second;
    logic              two;
    logic [CW-1:0]     n_push;

    always_comb
    begin
        two    = push_a && push_b;
        first  = push_a ? data_a : data_b;
        second = data_b;
        n_push = CW'(push_a) + CW'(push_b);
        tail_next  = tail_reg + PW'(n_push);
        head_next  = pop ? head_reg + PW'(1) : head_reg;
        count_next = count_reg + n_push - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a || push_b)
        begin
            mem_reg[tail_reg] <= first;
        end
        if (two)
        begin
            mem_reg[tail_reg + PW'(1)] <= second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[head_reg];
    assign count     = count_reg;

endmodule

FILE: hdl/box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
// Edge-aware 3x3 box blur: top level. Depends on bbea_pkg and all bbea_* modules.
// A result passes through stages 0, 1 and 2 before it is written to the output queue.
// Throughput: one request per cycle while the output queue has room; after the last
// pixel of a frame, requests wait while line store column 0 is fetched for the drain ticks.
// Reset (asynchronous, active low) restores 640x480, clears counters and the queue;
// the line stores and the window are not cleared and need no clearing pass.

module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = bbea_pkg::MAX_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbea_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [7:0]                     in_red,
    input  logic [7:0]                     in_green,
    input  logic [7:0]                     in_blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_red,
    output logic [7:0]                     out_green,
    output logic [7:0]                     out_blue,
    output logic                           last_in_run,
    output logic                           frame_end
);

    // AW addresses a line store; DW holds a column count up to MAX_WIDTH itself.
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int DW  = $clog2(MAX_WIDTH + 1);
    localparam int WCW = (DW > bbea_pkg::FW_W) ? DW : bbea_pkg::FW_W;
    localparam int QCW = $clog2(bbea_pkg::FIFO_DEPTH + 1);
    localparam int CRW = QCW + 3;

    // Configuration registers and frame position counters.
    logic [bbea_pkg::FW_W-1:0] fw_reg;
    logic [bbea_pkg::FH_W-1:0] fh_reg;
    logic [bbea_pkg::FH_W-1:0] row_reg, row_next;
    logic [AW-1:0]             col_reg, col_next;
    logic [DW-1:0]             drain_reg, drain_next;
    logic                      preload_reg, preload_next;

    logic [WCW-1:0]            w_wide;
    logic [DW-1:0]             w_eff;
    logic [bbea_pkg::FH_W-1:0] h_eff;

    // Front-end decode of the incoming request.
    logic          accept, pix_ok, drn_ok, last_col, frame_done, drain_last;
    logic [DW-1:0] drain_inc;
    logic [AW-1:0] rd_addr;
    bbea_pkg::ctrl_t in_ctrl;

    // Stage 0: line store data arrives, stores are updated, window shifts.
    logic             s0_valid_reg;
    bbea_pkg::ctrl_t  s0_ctrl_reg;
    bbea_pkg::pixel_t s0_pix_reg;
    logic [AW-1:0]    s0_addr_reg;
    logic             byp_reg, byp_next;
    bbea_pkg::pixel_t byp_old_reg, byp_new_reg;
    bbea_pkg::pixel_t older_q, newer_q, top_eff, mid_eff;
    logic             s0_we;

    bbea_pkg::pixel_t win_reg [3][3];

    // Stage 1: masked window sums; stage 2: rounded means into the queue.
    logic             s1_valid_reg;
    bbea_pkg::ctrl_t  s1_ctrl_reg;
    bbea_pkg::sum_t   sum_a, sum_b;
    logic [bbea_pkg::CNT_W-1:0] cnt_a, cnt_b;

    logic             s2_valid_reg;
    bbea_pkg::ctrl_t  s2_ctrl_reg;
    bbea_pkg::sum_t   s2_sum_a_reg, s2_sum_b_reg;
    logic [bbea_pkg::CNT_W-1:0] s2_cnt_a_reg, s2_cnt_b_reg;
    bbea_pkg::pixel_t mean_a, mean_b;
    bbea_pkg::result_t res_a, res_b, head;

    logic             push_a, push_b, q_not_empty;
    logic [QCW-1:0]   q_count;
    logic [CRW-1:0]   committed;

    // Zero width or height counts as one, widths beyond the line stores saturate.
    always_comb
    begin
        w_wide = WCW'(fw_reg);
        if (w_wide == '0)
        begin
            w_wide = WCW'(1);
        end
        if (w_wide > WCW'(MAX_WIDTH))
        begin
            w_wide = WCW'(MAX_WIDTH);
        end
        w_eff = DW'(w_wide);
        h_eff = (fh_reg == '0) ? bbea_pkg::FH_W'(1) : fh_reg;
    end

    // A request may enter only when the queue can absorb two results for it and
    // for every request still in flight, so no stage ever has to stall.
    always_comb
    begin
        committed = CRW'(q_count)
                  + (CRW'(s0_valid_reg) + CRW'(s1_valid_reg) + CRW'(s2_valid_reg)) * CRW'(2);
        in_ready  = !preload_reg && (committed <= CRW'(bbea_pkg::FIFO_DEPTH - 2));
        accept    = in_valid && in_ready;
    end

    // Request decode. A pixel after the whole frame, and a drain tick before it,
    // are taken but give nothing and leave no trace.
    always_comb
    begin
        last_col   = (DW'(col_reg) == (w_eff - DW'(1)));
        frame_done = (row_reg >= h_eff);
        drain_inc  = drain_reg + DW'(1);
        drain_last = (drain_inc == w_eff);
        pix_ok     = !req_type && !frame_done;
        drn_ok     = req_type && frame_done && (drain_reg < w_eff);

        if (preload_reg)
        begin
            rd_addr = '0;
        end
        else if (req_type)
        begin
            rd_addr = AW'(drain_inc);
        end
        else
        begin
            rd_addr = col_reg;
        end

        in_ctrl = '0;
        if (req_type)
        begin
            // Drain tick d covers columns d-1..d+1 of the last two rows. The fetch
            // of column 0 shares this slot with a waiting tick and gives no result.
            in_ctrl.va     = drn_ok && !preload_reg;
            in_ctrl.last_a = 1'b1;
            in_ctrl.fend_a = drain_last;
            in_ctrl.rowm   = {1'b0, 1'b1, (h_eff > bbea_pkg::FH_W'(1))};
            in_ctrl.cola   = {(drain_inc < w_eff), 1'b1, (drain_reg != '0)};
        end
        else
        begin
            // The centre result is one column back; the end-of-row result also
            // closes the last pixel of the row above.
            in_ctrl.wr     = pix_ok;
            in_ctrl.va     = pix_ok && (row_reg != '0) && (col_reg != '0);
            in_ctrl.vb     = pix_ok && (row_reg != '0) && last_col;
            in_ctrl.last_a = !last_col;
            in_ctrl.rowm   = {1'b1, 1'b1, (row_reg > bbea_pkg::FH_W'(1))};
            in_ctrl.cola   = {1'b1, 1'b1, (col_reg > AW'(1))};
            in_ctrl.colb   = {1'b1, (col_reg != '0), 1'b0};
        end
    end

    // Frame position. The final pixel of the frame schedules a one-cycle fetch of
    // column 0 so the drain window starts primed.
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        drain_next   = drain_reg;
        preload_next = 1'b0;
        if (accept && pix_ok)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = row_reg + bbea_pkg::FH_W'(1);
                preload_next = ((row_reg + bbea_pkg::FH_W'(1)) == h_eff);
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (accept && drn_ok)
        begin
            if (drain_last)
            begin
                row_next   = '0;
                col_next   = '0;
                drain_next = '0;
            end
            else
            begin
                drain_next = drain_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= bbea_pkg::FW_RESET;
            fh_reg      <= bbea_pkg::FH_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            drain_reg   <= '0;
            preload_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            // Any register write restarts the frame.
            unique case (cfg_index)
                bbea_pkg::REG_FRAME_WIDTH:  fw_reg <= bbea_pkg::FW_W'(cfg_data);
                bbea_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                default: ;
            endcase
            row_reg     <= '0;
            col_reg     <= '0;
            drain_reg   <= '0;
            preload_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            drain_reg   <= drain_next;
            preload_reg <= preload_next;
        end
    end

    // Line stores: the older store holds row r-2 and the newer one row r-1.
    bbea_ram #(
        .WIDTH ($bits(bbea_pkg::pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .clk   (clk),
        .we    (s0_we),
        .waddr (s0_addr_reg),
        .wdata (mid_eff),
        .raddr (rd_addr),
        .rdata (older_q)
    );

    bbea_ram #(
        .WIDTH ($bits(bbea_pkg::pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .clk   (clk),
        .we    (s0_we),
        .waddr (s0_addr_reg),
        .wdata (s0_pix_reg),
        .raddr (rd_addr),
        .rdata (newer_q)
    );

    // A read of the column being written in the same cycle returns stale data,
    // so the just-written values are forwarded in that case.
    always_comb
    begin
        top_eff  = byp_reg ? byp_old_reg : older_q;
        mid_eff  = byp_reg ? byp_new_reg : newer_q;
        s0_we    = s0_valid_reg && s0_ctrl_reg.wr;
        byp_next = s0_we && (s0_addr_reg == rd_addr);
    end

    always_ff @(posedge clk)
    begin
        s0_ctrl_reg  <= in_ctrl;
        s0_pix_reg   <= '{red: in_red, green: in_green, blue: in_blue};
        s0_addr_reg  <= rd_addr;
        byp_reg      <= byp_next;
        byp_old_reg  <= mid_eff;
        byp_new_reg  <= s0_pix_reg;
        if (s0_valid_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2][0] <= top_eff;
            win_reg[2][1] <= mid_eff;
            win_reg[2][2] <= s0_pix_reg;
        end
        s1_ctrl_reg  <= s0_ctrl_reg;
        s2_ctrl_reg  <= s1_ctrl_reg;
        s2_sum_a_reg <= sum_a;
        s2_sum_b_reg <= sum_b;
        s2_cnt_a_reg <= cnt_a;
        s2_cnt_b_reg <= cnt_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= (accept && (pix_ok || drn_ok)) || preload_reg;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    bbea_win_sum u_sum_a (
        .win   (win_reg),
        .colm  (s1_ctrl_reg.cola),
        .rowm  (s1_ctrl_reg.rowm),
        .sums  (sum_a),
        .count (cnt_a)
    );

    bbea_win_sum u_sum_b (
        .win   (win_reg),
        .colm  (s1_ctrl_reg.colb),
        .rowm  (s1_ctrl_reg.rowm),
        .sums  (sum_b),
        .count (cnt_b)
    );

    bbea_mean u_mean_a (
        .sums  (s2_sum_a_reg),
        .count (s2_cnt_a_reg),
        .mean  (mean_a)
    );

    bbea_mean u_mean_b (
        .sums  (s2_sum_b_reg),
        .count (s2_cnt_b_reg),
        .mean  (mean_b)
    );

    always_comb
    begin
        push_a = s2_valid_reg && s2_ctrl_reg.va;
        push_b = s2_valid_reg && s2_ctrl_reg.vb;
        res_a  = '{pix: mean_a, last: s2_ctrl_reg.last_a, fend: s2_ctrl_reg.fend_a};
        res_b  = '{pix: mean_b, last: 1'b1, fend: 1'b0};
    end

    bbea_out_fifo #(
        .DEPTH (bbea_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .data_a    (res_a),
        .push_b    (push_b),
        .data_b    (res_b),
        .pop       (out_valid && out_ready),
        .not_empty (q_not_empty),
        .head_data (head),
        .count     (q_count)
    );

    assign out_valid   = q_not_empty;
    assign out_red     = head.pix.red;
    assign out_green   = head.pix.green;
    assign out_blue    = head.pix.blue;
    assign last_in_run = head.last;
    assign frame_end   = head.fend;

endmodule
